// ===== rtl/flvs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow limited valve sequencer package
// Shared codes, widths and beat types for the valve sequencer.
// ----------------------------------------------------------------------------
package flvs_pkg;

    localparam int CMD_W       = 3;
    localparam int ACTION_W    = 3;
    localparam int OUTLET_W    = 6;
    localparam int STOP_W      = 2;
    localparam int PPM_W       = 8;
    localparam int ML_W        = 16;
    localparam int SEC_W       = 16;
    localparam int ELAPSED_W   = 26;
    localparam int TIME_LIM_W  = 26;
    localparam int PULSE_LIM_W = 24;
    localparam int COUNT_W     = 32;
    localparam int MS_PER_S    = 1000;

    localparam logic [PPM_W-1:0] PPM_RESET = 8'd7;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_PULSE     = 3'd1,
        CMD_REFILL    = 3'd2,
        CMD_DRAIN     = 3'd3,
        CMD_WATER     = 3'd4,
        CMD_CLEAN     = 3'd5,
        CMD_RESET_CNT = 3'd6
    } cmd_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_IDLE   = 3'd0,
        ACT_REFILL = 3'd1,
        ACT_DRAIN  = 3'd2,
        ACT_WATER  = 3'd3,
        ACT_CLEAN  = 3'd4
    } action_t;

    typedef enum logic [STOP_W-1:0] {
        STOP_NONE   = 2'd0,
        STOP_LEVEL  = 2'd1,
        STOP_TIME   = 2'd2,
        STOP_VOLUME = 2'd3
    } stop_t;

    // Outlet bit order: pump, inlet primary, inlet secondary, flush, drain, water.
    localparam logic [OUTLET_W-1:0] BIT_PUMP      = 6'h01;
    localparam logic [OUTLET_W-1:0] BIT_IN_PRI    = 6'h02;
    localparam logic [OUTLET_W-1:0] BIT_IN_SEC    = 6'h04;
    localparam logic [OUTLET_W-1:0] BIT_OUT_FLUSH = 6'h08;
    localparam logic [OUTLET_W-1:0] BIT_OUT_DRAIN = 6'h10;
    localparam logic [OUTLET_W-1:0] BIT_OUT_WATER = 6'h20;

    localparam logic [OUTLET_W-1:0] VALVES_REFILL = BIT_PUMP | BIT_IN_SEC | BIT_OUT_FLUSH;
    localparam logic [OUTLET_W-1:0] VALVES_DRAIN  = BIT_PUMP | BIT_IN_PRI | BIT_OUT_DRAIN;
    localparam logic [OUTLET_W-1:0] VALVES_WATER  = BIT_PUMP | BIT_IN_PRI | BIT_OUT_WATER;
    localparam logic [OUTLET_W-1:0] VALVES_CLEAN  = BIT_PUMP | BIT_IN_SEC | BIT_OUT_DRAIN;

    typedef struct packed {
        cmd_t                   cmd;
        logic                   level;
        logic [TIME_LIM_W-1:0]  time_limit;
        logic [PULSE_LIM_W-1:0] pulse_limit;
    } event_t;

    typedef struct packed {
        logic signed [COUNT_W-1:0] flow_count;
        stop_t                     stop;
        logic [OUTLET_W-1:0]       outlets;
        action_t                   action;
    } result_t;

endpackage

// ===== rtl/flvs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Valve sequencer control state
// Holds the action state and counters and applies one event per cycle while step is high.
// ----------------------------------------------------------------------------
module flvs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  flvs_pkg::event_t evt,
    output flvs_pkg::result_t res
);
    import flvs_pkg::*;

    action_t                   action_reg, action_next;
    logic [OUTLET_W-1:0]       outlet_reg, outlet_next;
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic [TIME_LIM_W-1:0]     tlim_reg, tlim_next;
    logic [PULSE_LIM_W-1:0]    plim_reg, plim_next;
    logic [COUNT_W-1:0]        pstart_reg, pstart_next;
    logic [COUNT_W-1:0]        pcount_reg, pcount_next;

    action_t                   act_s;
    logic [OUTLET_W-1:0]       out_s;
    logic [ELAPSED_W-1:0]      el_s;
    logic [TIME_LIM_W-1:0]     tl_s;
    logic [PULSE_LIM_W-1:0]    pl_s;
    logic [COUNT_W-1:0]        ps_s;
    logic [COUNT_W-1:0]        delta;
    logic [COUNT_W-1:0]        mag;
    logic                      start;
    action_t                   start_act;
    logic [OUTLET_W-1:0]       start_bits;
    stop_t                     reason;

    always_comb
    begin
        start      = 1'b1;
        start_act  = ACT_IDLE;
        start_bits = '0;
        case (evt.cmd)
            CMD_REFILL:
            begin
                start_act  = ACT_REFILL;
                start_bits = VALVES_REFILL;
            end
            CMD_DRAIN:
            begin
                start_act  = ACT_DRAIN;
                start_bits = VALVES_DRAIN;
            end
            CMD_WATER:
            begin
                start_act  = ACT_WATER;
                start_bits = VALVES_WATER;
            end
            CMD_CLEAN:
            begin
                start_act  = ACT_CLEAN;
                start_bits = VALVES_CLEAN;
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        act_s       = action_reg;
        out_s       = outlet_reg;
        el_s        = elapsed_reg;
        tl_s        = tlim_reg;
        pl_s        = plim_reg;
        ps_s        = pstart_reg;
        pcount_next = pcount_reg;

        case (evt.cmd)
            CMD_TICK:
            begin
                if (action_reg != ACT_IDLE && elapsed_reg != {ELAPSED_W{1'b1}})
                begin
                    el_s = elapsed_reg + ELAPSED_W'(1);
                end
            end
            CMD_PULSE:
            begin
                if (action_reg == ACT_REFILL)
                begin
                    pcount_next = pcount_reg + COUNT_W'(1);
                end
                else
                begin
                    pcount_next = pcount_reg - COUNT_W'(1);
                end
            end
            CMD_RESET_CNT:
            begin
                pcount_next = '0;
            end
            default:
            begin
            end
        endcase

        if (start)
        begin
            act_s = start_act;
            out_s = outlet_reg | start_bits;
            el_s  = '0;
            tl_s  = evt.time_limit;
            pl_s  = evt.pulse_limit;
            ps_s  = pcount_reg;
        end

        delta  = pcount_next - ps_s;
        mag    = delta[COUNT_W-1] ? (COUNT_W'(0) - delta) : delta;
        reason = STOP_NONE;
        if (act_s != ACT_IDLE)
        begin
            if ((act_s == ACT_REFILL || act_s == ACT_CLEAN) && evt.level)
            begin
                reason = STOP_LEVEL;
            end
            else if (el_s >= tl_s)
            begin
                reason = STOP_TIME;
            end
            else if (mag >= {{(COUNT_W-PULSE_LIM_W){1'b0}}, pl_s})
            begin
                reason = STOP_VOLUME;
            end
        end

        action_next  = act_s;
        outlet_next  = out_s;
        elapsed_next = el_s;
        tlim_next    = tl_s;
        plim_next    = pl_s;
        pstart_next  = ps_s;
        if (reason != STOP_NONE)
        begin
            action_next  = ACT_IDLE;
            outlet_next  = '0;
            elapsed_next = '0;
            tlim_next    = '0;
            plim_next    = '0;
            pstart_next  = '0;
        end

        res.action     = action_next;
        res.outlets    = outlet_next;
        res.stop       = reason;
        res.flow_count = pcount_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            action_reg  <= ACT_IDLE;
            outlet_reg  <= '0;
            elapsed_reg <= '0;
            tlim_reg    <= '0;
            plim_reg    <= '0;
            pstart_reg  <= '0;
            pcount_reg  <= '0;
        end
        else if (step)
        begin
            action_reg  <= action_next;
            outlet_reg  <= outlet_next;
            elapsed_reg <= elapsed_next;
            tlim_reg    <= tlim_next;
            plim_reg    <= plim_next;
            pstart_reg  <= pstart_next;
            pcount_reg  <= pcount_next;
        end
    end

endmodule

// ===== rtl/flow_limited_valve_sequencer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow limited valve sequencer
// Sequences pump and valves for refill, drain, water and clean actions.
// ----------------------------------------------------------------------------
// Events enter on the s_axis channel: the command code in tuser, the level
// switch and the volume and time limits in tdata. Each event beat yields
// exactly one result beat on the m_axis channel carrying the action, the
// pump and valve drives, the stop reason and the signed flow counter.
// An accepted beat is registered together with its time and volume limit
// products, then applied to the sequencer state and captured in the result
// register once that register is empty or being taken. One event is accepted
// per cycle as long as the result register is empty or being taken in the
// same cycle. When the receiver stalls, one event waits in the input register
// and s_axis_tready drops until the result moves on. Reset clears both
// stages, idles the sequencer, zeroes the flow counter and sets pulses_per_ml
// to 7. The user must write pulses_per_ml through cfg_wr_en and cfg_wr_data
// only while no event is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module flow_limited_valve_sequencer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,    // pulses_per_ml
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // level_reached, max_ml, max_seconds
    input  logic [2:0]  s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // action, pump_on, valve_in_primary,
                                        // valve_in_secondary, valve_out_flush,
                                        // valve_out_drain, valve_out_water,
                                        // stop_reason, flow_count
);
    import flvs_pkg::*;

    logic [PPM_W-1:0] ppm_reg;
    logic             in_valid_reg;
    event_t           in_reg;
    event_t           in_next;
    logic             out_valid_reg;
    result_t          out_reg;
    result_t          res;
    logic             step;
    logic [ML_W-1:0]  max_ml;
    logic [SEC_W-1:0] max_seconds;

    assign max_ml      = s_axis_tdata[16:1];
    assign max_seconds = s_axis_tdata[32:17];

    assign step          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || step;

    always_comb
    begin
        in_next.cmd         = cmd_t'(s_axis_tuser);
        in_next.level       = s_axis_tdata[0];
        in_next.time_limit  = TIME_LIM_W'({{(TIME_LIM_W-SEC_W){1'b0}}, max_seconds}
                              * TIME_LIM_W'(MS_PER_S));
        in_next.pulse_limit = {{(PULSE_LIM_W-ML_W){1'b0}}, max_ml}
                              * {{(PULSE_LIM_W-PPM_W){1'b0}}, ppm_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppm_reg <= PPM_RESET;
        end
        else if (cfg_wr_en)
        begin
            ppm_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_reg <= in_next;
        end
        if (step)
        begin
            out_reg <= res;
        end
    end

    flvs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .evt   (in_reg),
        .res   (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.flow_count, out_reg.stop,
                            out_reg.outlets, out_reg.action};

endmodule
